FILE: src/stqg_pkg.sv
// Shared constants, codes and control/status types of the tiled sprite quad generator.
package stqg_pkg;

	localparam int MAX_QUADS       = 64;
	localparam int COORD_FRAC_BITS = 8;

	localparam int CW   = 20;                          // Q12.8 coordinate
	localparam int SZW  = 13;                          // texture size
	localparam int UVW  = 17;                          // Q1.16 texture coordinate, 0..65536
	localparam int BSW  = CW + 1;                      // start skew
	localparam int X1W  = CW + 2;                      // texel position of a tile edge
	localparam int TPW  = CW + 3;                      // texel position incl. tile extent
	localparam int NW   = $clog2(MAX_QUADS + 1);       // quad counter
	localparam int CIW  = 3;                           // config register index
	localparam int QTW  = 16;                          // quotient bits below saturation

	// config register indexes
	localparam logic [CIW-1:0] REG_TEX_W   = 3'd0;
	localparam logic [CIW-1:0] REG_TEX_H   = 3'd1;
	localparam logic [CIW-1:0] REG_FRAME_W = 3'd2;
	localparam logic [CIW-1:0] REG_FRAME_H = 3'd3;
	localparam logic [CIW-1:0] REG_SRC_X   = 3'd4;
	localparam logic [CIW-1:0] REG_SRC_Y   = 3'd5;

	// repeat modes
	localparam logic [1:0] MODE_REP_X = 2'd0;
	localparam logic [1:0] MODE_REP_Y = 2'd1;

	// texture coordinate being divided
	localparam logic [1:0] SEL_UL = 2'd0;
	localparam logic [1:0] SEL_UR = 2'd1;
	localparam logic [1:0] SEL_VT = 2'd2;
	localparam logic [1:0] SEL_VB = 2'd3;

	typedef struct packed {
		logic       load;
		logic       setup;
		logic       tile;
		logic       div_start;
		logic       div_store;
		logic [1:0] div_sel;
		logic       advance;
	} stqg_cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
		logic x_more;
		logic y_more;
		logic at_max;
	} stqg_sts_t;

endpackage

FILE: src/stqg_div.sv
// Bit-serial divider: saturating texel position to Q0.16 quotient, one bit per cycle.
module stqg_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [stqg_pkg::TPW-1:0] pos,
	input  logic [stqg_pkg::SZW-1:0] size,
	output logic                     done,
	output logic                     ovf,
	output logic [stqg_pkg::QTW-1:0] quot
);
	import stqg_pkg::*;

	localparam int DW   = TPW + QTW;
	localparam int CNTW = $clog2(QTW + 1);

	logic [DW-1:0]    dvd;
	logic [SZW:0]     trial;
	logic             ge;
	logic [SZW-1:0]   rem_q;
	logic [SZW-1:0]   size_q;
	logic [QTW-1:0]   sh_q;
	logic [QTW-1:0]   quot_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf_q;

	// dividend scaled so the quotient lands in Q0.16
	assign dvd   = DW'(pos) << (QTW - COORD_FRAC_BITS);
	assign trial = {rem_q, sh_q[QTW-1]};
	assign ge    = trial >= {1'b0, size_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QTW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division step
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q  <= (TPW+1)'(pos) >= ((TPW+1)'(size) << COORD_FRAC_BITS);
			rem_q  <= SZW'(dvd >> QTW);
			sh_q   <= dvd[QTW-1:0];
			quot_q <= '0;
			size_q <= size;
		end else if (busy_q) begin
			rem_q  <= ge ? SZW'(trial - {1'b0, size_q}) : trial[SZW-1:0];
			sh_q   <= {sh_q[QTW-2:0], 1'b0};
			quot_q <= {quot_q[QTW-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quot_q;

endmodule

FILE: src/stqg_datapath.sv
// Datapath: config registers, request set-up, tile geometry and texture coordinates.
module stqg_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  stqg_pkg::stqg_cmd_t       cmd,
	output stqg_pkg::stqg_sts_t       sts,
	input  logic                      cfg_we,
	input  logic [stqg_pkg::CIW-1:0]  cfg_index,
	input  logic [stqg_pkg::CW-1:0]   cfg_data,
	input  logic [stqg_pkg::CW-1:0]   pos_x,
	input  logic [stqg_pkg::CW-1:0]   pos_y,
	input  logic [stqg_pkg::CW-1:0]   area_left,
	input  logic [stqg_pkg::CW-1:0]   area_top,
	input  logic [stqg_pkg::CW-1:0]   area_right,
	input  logic [stqg_pkg::CW-1:0]   area_bottom,
	input  logic [1:0]                mode,
	input  logic                      mirror,
	input  logic [15:0]               depth_z,
	input  logic [31:0]               color,
	output logic [stqg_pkg::CW-1:0]   quad_x,
	output logic [stqg_pkg::CW-1:0]   quad_y,
	output logic [stqg_pkg::CW-1:0]   quad_w,
	output logic [stqg_pkg::CW-1:0]   quad_h,
	output logic [stqg_pkg::UVW-1:0]  u_left,
	output logic [stqg_pkg::UVW-1:0]  u_right,
	output logic [stqg_pkg::UVW-1:0]  v_top,
	output logic [stqg_pkg::UVW-1:0]  v_bottom,
	output logic [15:0]               out_depth,
	output logic [31:0]               out_color
);
	import stqg_pkg::*;

	localparam logic [UVW-1:0] UV_ONE = UVW'(1 << QTW);

	// config
	logic [SZW-1:0] tex_w_q, tex_h_q;
	logic [CW-1:0]  frame_w_q, frame_h_q, src_x_q, src_y_q;

	// request
	logic [CW-1:0]  px_q, py_q, left_q, top_q, ex_q, ey_q;
	logic           rep_x_q, rep_y_q, mirror_q;
	logic [15:0]    depth_q;
	logic [31:0]    color_q;

	// walk state
	logic [BSW-1:0] bsx_q, bsy_q;
	logic [CW-1:0]  cx_q, rx_q, ry_q, nrx_q, nry_q;
	logic           fx_q, fy_q, x_more_q, y_more_q;
	logic [NW-1:0]  n_q;
	logic [CW-1:0]  dx_q, dy_q;
	logic [X1W-1:0] x1_q, y1_q;
	logic [UVW-1:0] ul_q, ur_q, vt_q, vb_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q   <= SZW'(256);
			tex_h_q   <= SZW'(256);
			frame_w_q <= CW'(8192);
			frame_h_q <= CW'(8192);
			src_x_q   <= '0;
			src_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_W:   tex_w_q   <= cfg_data[SZW-1:0];
				REG_TEX_H:   tex_h_q   <= cfg_data[SZW-1:0];
				REG_FRAME_W: frame_w_q <= cfg_data;
				REG_FRAME_H: frame_h_q <= cfg_data;
				REG_SRC_X:   src_x_q   <= cfg_data;
				REG_SRC_Y:   src_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q     <= pos_x;
			py_q     <= pos_y;
			left_q   <= area_left;
			top_q    <= area_top;
			ex_q     <= area_right;
			ey_q     <= area_bottom;
			rep_x_q  <= mode != MODE_REP_Y;
			rep_y_q  <= mode != MODE_REP_X;
			mirror_q <= mirror;
			depth_q  <= depth_z;
			color_q  <= color;
		end
	end

	// set-up: start point and start skew
	logic [BSW-1:0] pfx, pfy, bsx0, bsy0, bsx_s, bsy_s;
	logic [CW-1:0]  cx_s, cy_s;
	logic           clip_x;

	always_comb begin
		pfx    = BSW'(px_q) + BSW'(frame_w_q);
		pfy    = BSW'(py_q) + BSW'(frame_h_q);
		bsx0   = (BSW'(left_q) > pfx) ? BSW'(left_q) - pfx : '0;
		bsy0   = (BSW'(top_q) > pfy) ? BSW'(top_q) - pfy : '0;
		clip_x = !rep_x_q && (px_q < left_q);
		bsx_s  = clip_x ? bsx0 + BSW'(left_q - px_q) : bsx0;
		bsy_s  = bsy0;
		cx_s   = (rep_x_q || clip_x) ? left_q : px_q;
		cy_s   = rep_y_q ? top_q : py_q;
	end

	// tile geometry and the step to the next tile
	logic [BSW-1:0] skx, sky, limx, limy;
	logic [CW-1:0]  remx, remy, dx_s, dy_s;
	logic [X1W-1:0] nx, ny;

	always_comb begin
		skx  = fx_q ? bsx_q : '0;
		sky  = fy_q ? bsy_q : '0;
		limx = (BSW'(frame_w_q) > skx) ? BSW'(frame_w_q) - skx : '0;
		limy = (BSW'(frame_h_q) > sky) ? BSW'(frame_h_q) - sky : '0;
		remx = ex_q - rx_q;
		remy = ey_q - ry_q;
		dx_s = (limx < BSW'(remx)) ? CW'(limx) : remx;
		dy_s = (limy < BSW'(remy)) ? CW'(limy) : remy;
		nx   = X1W'(rx_q) + X1W'(frame_w_q) - X1W'(skx);
		ny   = X1W'(ry_q) + X1W'(frame_h_q) - X1W'(sky);
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= 1'b1;
			fy_q <= 1'b1;
			n_q  <= '0;
		end else if (cmd.setup) begin
			fx_q <= 1'b1;
			fy_q <= 1'b1;
			n_q  <= '0;
		end else if (cmd.advance) begin
			n_q <= n_q + 1'b1;
			if (x_more_q) begin
				fx_q <= 1'b0;
			end else begin
				fx_q <= 1'b1;
				fy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			bsx_q <= bsx_s;
			bsy_q <= bsy_s;
			cx_q  <= cx_s;
			rx_q  <= cx_s;
			ry_q  <= cy_s;
		end else if (cmd.advance) begin
			if (x_more_q) begin
				rx_q <= nrx_q;
			end else begin
				rx_q <= cx_q;
				ry_q <= nry_q;
			end
		end
		if (cmd.tile) begin
			dx_q     <= dx_s;
			dy_q     <= dy_s;
			x1_q     <= X1W'(src_x_q) + X1W'(skx);
			y1_q     <= X1W'(src_y_q) + X1W'(sky);
			nrx_q    <= CW'(nx);
			nry_q    <= CW'(ny);
			x_more_q <= rep_x_q && (nx < X1W'(ex_q));
			y_more_q <= rep_y_q && (ny < X1W'(ey_q));
		end
	end

	// texture coordinate division
	logic [TPW-1:0] div_pos;
	logic [SZW-1:0] div_size, tw_eff, th_eff;
	logic           div_done, div_ovf;
	logic [QTW-1:0] div_quot;
	logic [UVW-1:0] u_val, v_val;

	always_comb begin
		tw_eff = (tex_w_q == '0) ? SZW'(1) : tex_w_q;
		th_eff = (tex_h_q == '0) ? SZW'(1) : tex_h_q;
		case (cmd.div_sel)
			SEL_UL:  div_pos = TPW'(x1_q);
			SEL_UR:  div_pos = TPW'(x1_q) + TPW'(dx_q);
			SEL_VT:  div_pos = TPW'(y1_q);
			SEL_VB:  div_pos = TPW'(y1_q) + TPW'(dy_q);
			default: div_pos = '0;
		endcase
		div_size = (cmd.div_sel == SEL_UL || cmd.div_sel == SEL_UR) ? tw_eff : th_eff;
		u_val    = div_ovf ? UV_ONE : UVW'(div_quot);
		v_val    = div_ovf ? '0 : UV_ONE - UVW'(div_quot);
	end

	stqg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.pos    (div_pos),
		.size   (div_size),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_sel)
				SEL_UL:  ul_q <= u_val;
				SEL_UR:  ur_q <= u_val;
				SEL_VT:  vt_q <= v_val;
				SEL_VB:  vb_q <= v_val;
				default: ;
			endcase
		end
	end

	// status
	assign sts.empty    = (cx_s >= ex_q) || (cy_s >= ey_q);
	assign sts.div_done = div_done;
	assign sts.x_more   = x_more_q;
	assign sts.y_more   = y_more_q;
	assign sts.at_max   = n_q == NW'(MAX_QUADS - 1);

	// result fields
	assign quad_x    = rx_q;
	assign quad_y    = ry_q;
	assign quad_w    = dx_q;
	assign quad_h    = dy_q;
	assign u_left    = mirror_q ? ur_q : ul_q;
	assign u_right   = mirror_q ? ul_q : ur_q;
	assign v_top     = vt_q;
	assign v_bottom  = vb_q;
	assign out_depth = depth_q;
	assign out_color = color_q;

endmodule

FILE: src/stqg_ctrl.sv
// Controller: sequences set-up, per-tile geometry, four divisions and the quad transfer.
module stqg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 last,
	output logic                 truncated,
	output stqg_pkg::stqg_cmd_t  cmd,
	input  stqg_pkg::stqg_sts_t  sts
);
	import stqg_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SETUP  = 3'd1;
	localparam logic [2:0] S_TILE   = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DWAIT  = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic       more;

	assign more = sts.x_more || sts.y_more;

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		last        = !more || sts.at_max;
		truncated   = more && sts.at_max;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.empty ? S_IDLE : S_TILE;
			end
			S_TILE: begin
				cmd.tile = 1'b1;
				sel_d    = SEL_UL;
				state_d  = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == SEL_VB) begin
						state_d = S_EMIT;
					end else begin
						sel_d   = sel_q + 1'b1;
						state_d = S_DSTART;
					end
				end
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (last) begin
						state_d = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_TILE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_UL;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

FILE: src/sprite_tile_quad_generator_core.sv
// Top level of the tiled sprite quad generator: controller, datapath and assertions.
//
// One request is taken at a time and yields up to MAX_QUADS quads, one per tile that
// covers the clip area, in row-major order; last marks the final quad and truncated
// marks it when more tiles existed. After a request transfer, a set-up step follows
// (a request that covers nothing yields no quad and frees the input right after it).
// Each quad then takes a geometry step, four texture divisions on one shared
// bit-serial divider and an output step, plus however long out_ready stays low; the
// input is ready again in the cycle after the last quad transfer. The input is ready
// only while no request is in progress. Configuration writes are always accepted,
// but the frame size is read throughout the tile walk, so registers should be
// written only while no request is in progress.
module sprite_tile_quad_generator_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [stqg_pkg::CIW-1:0]  cfg_index,
	input  logic [stqg_pkg::CW-1:0]   cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [stqg_pkg::CW-1:0]   pos_x,
	input  logic [stqg_pkg::CW-1:0]   pos_y,
	input  logic [stqg_pkg::CW-1:0]   area_left,
	input  logic [stqg_pkg::CW-1:0]   area_top,
	input  logic [stqg_pkg::CW-1:0]   area_right,
	input  logic [stqg_pkg::CW-1:0]   area_bottom,
	input  logic [1:0]                mode,
	input  logic                      mirror,
	input  logic [15:0]               depth_z,
	input  logic [31:0]               color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [stqg_pkg::CW-1:0]   quad_x,
	output logic [stqg_pkg::CW-1:0]   quad_y,
	output logic [stqg_pkg::CW-1:0]   quad_w,
	output logic [stqg_pkg::CW-1:0]   quad_h,
	output logic [stqg_pkg::UVW-1:0]  u_left,
	output logic [stqg_pkg::UVW-1:0]  u_right,
	output logic [stqg_pkg::UVW-1:0]  v_top,
	output logic [stqg_pkg::UVW-1:0]  v_bottom,
	output logic [15:0]               out_depth,
	output logic [31:0]               out_color,
	output logic                      last,
	output logic                      truncated
);
	import stqg_pkg::*;

	stqg_cmd_t cmd;
	stqg_sts_t sts;

	assign cfg_ready = 1'b1;

	stqg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last),
		.truncated (truncated),
		.cmd       (cmd),
		.sts       (sts)
	);

	stqg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.area_left   (area_left),
		.area_top    (area_top),
		.area_right  (area_right),
		.area_bottom (area_bottom),
		.mode        (mode),
		.mirror      (mirror),
		.depth_z     (depth_z),
		.color       (color),
		.quad_x      (quad_x),
		.quad_y      (quad_y),
		.quad_w      (quad_w),
		.quad_h      (quad_h),
		.u_left      (u_left),
		.u_right     (u_right),
		.v_top       (v_top),
		.v_bottom    (v_bottom),
		.out_depth   (out_depth),
		.out_color   (out_color)
	);

`ifndef SYNTHESIS
	// truncation is flagged only on the final quad
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> last)
		else $error("truncated without last");

	// no new request while a quad is pending
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while quad pending");

	// the final quad transfer ends the request
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid && in_ready)
		else $error("request did not end after last quad");

	// a quad transfer that is not last is followed by geometry work, not an idle input
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready && !out_valid)
		else $error("walk stopped early");
`endif

endmodule
